// File: rtl/b2d_pkg.sv
package b2d_pkg;

	// Field widths
	localparam int VALUE_W    = 63;
	localparam int MAX_DIGITS = 19;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
	localparam int CNT_W      = 5;
	localparam int CHAR_W     = 6;
	localparam int BITCNT_W   = $clog2(VALUE_W);

	// ASCII '0' prefix: digit + 48 is {2'b11, digit} for digits 0..9
	localparam logic [CHAR_W-DIGIT_W-1:0] ASCII_HI = 2'b11;

	typedef logic [BCD_W-1:0] bcd_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_RUN,
		C_DONE
	} conv_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_SKIP,
		E_SEND
	} emit_state_t;

	// Add 3 to every BCD digit of 5 or more before the next shift
	function automatic bcd_t bcd_adjust(input bcd_t b);
		bcd_t r;
		r = b;
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (b[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
				r[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
		end
		return r;
	endfunction

endpackage

// File: rtl/b2d_dabble.sv
module b2d_dabble (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [b2d_pkg::VALUE_W-1:0] in_value,
	output logic                     hand_valid,
	input  logic                     hand_ready,
	output b2d_pkg::bcd_t            hand_bcd
);
	import b2d_pkg::*;

	conv_state_t           state_q, state_d;
	logic [VALUE_W-1:0]    val_q;
	bcd_t                  bcd_q;
	bcd_t                  bcd_adj;
	logic [BITCNT_W-1:0]   bit_q;
	logic                  last_bit;

	assign last_bit   = (bit_q == BITCNT_W'(VALUE_W - 1));
	assign in_ready   = (state_q == C_IDLE);
	assign hand_valid = (state_q == C_DONE);
	assign hand_bcd   = bcd_q;
	assign bcd_adj    = bcd_adjust(bcd_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (in_valid) state_d = C_RUN;
			C_RUN:  if (last_bit) state_d = C_DONE;
			C_DONE: if (hand_ready) state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == C_IDLE)
				bit_q <= '0;
			else if (state_q == C_RUN)
				bit_q <= bit_q + BITCNT_W'(1);
		end
	end

	// Shift one value bit per cycle into the adjusted BCD register
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && in_valid) begin
			val_q <= in_value;
			bcd_q <= '0;
		end else if (state_q == C_RUN) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], val_q[VALUE_W-1]};
			val_q <= {val_q[VALUE_W-2:0], 1'b0};
		end
	end

endmodule

// File: rtl/b2d_emit.sv
module b2d_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     hand_valid,
	output logic                     hand_ready,
	input  b2d_pkg::bcd_t            hand_bcd,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [b2d_pkg::CHAR_W-1:0] out_char,
	output logic [b2d_pkg::CNT_W-1:0]  out_count,
	output logic                     out_last
);
	import b2d_pkg::*;

	emit_state_t         state_q, state_d;
	bcd_t                bcd_q;
	logic [CNT_W-1:0]    zeros_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    left_q;
	logic [DIGIT_W-1:0]  top_digit;
	logic                skip;
	logic                fire;

	assign top_digit  = bcd_q[BCD_W-1 -: DIGIT_W];
	assign skip       = (top_digit == '0) && (zeros_q != CNT_W'(MAX_DIGITS - 1));
	assign fire       = out_valid && out_ready;
	assign hand_ready = (state_q == E_IDLE);
	assign out_valid  = (state_q == E_SEND);
	assign out_char   = {ASCII_HI, top_digit};
	assign out_count  = count_q;
	assign out_last   = (left_q == CNT_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: if (hand_valid) state_d = E_SKIP;
			E_SKIP: if (!skip) state_d = E_SEND;
			E_SEND: if (fire && out_last) state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			zeros_q <= '0;
			count_q <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				E_IDLE: zeros_q <= '0;
				E_SKIP: begin
					if (skip) begin
						zeros_q <= zeros_q + CNT_W'(1);
					end else begin
						count_q <= CNT_W'(MAX_DIGITS) - zeros_q;
						left_q  <= CNT_W'(MAX_DIGITS) - zeros_q;
					end
				end
				E_SEND: if (fire) left_q <= left_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	// Drop leading zeros, then shift out one digit per word
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && hand_valid)
			bcd_q <= hand_bcd;
		else if ((state_q == E_SKIP && skip) || (state_q == E_SEND && fire))
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
	end

endmodule

// File: rtl/binary_to_decimal_ascii_top.sv
// Converts one unsigned 63-bit integer per input word into its decimal ASCII
// digits, most significant first, one digit per output word, with no leading
// zeros (zero gives a single '0'); each word also carries the digit count and
// tlast marks the final digit. A double-dabble converter shifts in one value
// bit per cycle, holds the result until the emitter takes it and then returns
// to idle to take the next word. The digit emitter first drops the leading
// zeros one by one and finds the first digit, then sends one digit per cycle
// while the sink is ready. The converter works on the next value while the
// emitter sends the previous one; a stalled sink holds the emitter, then the
// converter, and then the input.
module binary_to_decimal_ascii_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [62:0] value, [63] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] digit_char, [10:6] digit_count, [15:11] zero
	output logic        m_tlast    // is_last
);
	import b2d_pkg::*;

	logic                 hand_valid;
	logic                 hand_ready;
	bcd_t                 hand_bcd;
	logic [CHAR_W-1:0]    digit_char;
	logic [CNT_W-1:0]     digit_count;

	b2d_dabble u_dabble (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_value   (s_tdata[VALUE_W-1:0]),
		.hand_valid (hand_valid),
		.hand_ready (hand_ready),
		.hand_bcd   (hand_bcd)
	);

	b2d_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand_valid (hand_valid),
		.hand_ready (hand_ready),
		.hand_bcd   (hand_bcd),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_char   (digit_char),
		.out_count  (digit_count),
		.out_last   (m_tlast)
	);

	// Pack the output word
	assign m_tdata = {5'b0, digit_count, digit_char};

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("converter accepted a word while busy");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] <= 4'd9))
		else $error("emitted digit is not decimal");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (digit_count != '0) && (digit_count <= CNT_W'(MAX_DIGITS)))
		else $error("digit count out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output continued after last digit");
`endif

endmodule
